/* hdl/assert_macros.svh */
// Assertion macros used by the checker module of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define CFR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/cfr_pkg.sv */
// Package with types and constants of the command frame receiver.
package cfr_pkg;

   localparam int CmdWidth         = 3;
   localparam int ByteWidth        = 8;
   localparam int LenWidth         = 4;
   localparam int CountWidth       = 3;
   localparam int PayloadBytes     = 6;
   localparam int PayloadWidth     = PayloadBytes * ByteWidth;
   localparam int TickWidth        = 16;
   localparam int NumLenRegs       = 4;
   localparam int HeaderBytes      = 3;
   localparam int MinFrameLen      = 4;
   localparam int NumCommandsDflt  = 4;

   localparam int CsrIndexWidth    = 3;
   localparam int CsrDataWidth     = 16;

   localparam logic [CsrIndexWidth-1:0] CsrTimeout      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrFrameLenBase = 3'd1;

   localparam logic [TickWidth-1:0] TimeoutReset = 16'd10;

   typedef logic [NumLenRegs-1:0][LenWidth-1:0] len_table_type;

   localparam len_table_type LenTableReset = {4'd4, 4'd4, 4'd10, 4'd4};

   typedef enum logic [1:0] {
      PhIdle  = 2'd0,
      PhLenHi = 2'd1,
      PhLenLo = 2'd2,
      PhBody  = 2'd3
   } phase_type;

   typedef struct packed {
      logic                 mode;
      logic [ByteWidth-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [CmdWidth-1:0]     command;
      logic                    status;
      logic [CountWidth-1:0]   payload_count;
      logic [PayloadWidth-1:0] payload;
   } result_type;

endpackage

/* hdl/cfr_if.sv */
// Valid/ready channel interfaces for the request and result items.
interface cfr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [cfr_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cfr_pkg::CmdWidth-1:0]     command;
   logic                             status;
   logic [cfr_pkg::CountWidth-1:0]   payload_count;
   logic [cfr_pkg::PayloadWidth-1:0] payload;

   modport source (output valid, output command, output status, output payload_count,
                   output payload, input ready);
   modport sink   (input valid, input command, input status, input payload_count,
                   input payload, output ready);
endinterface

/* hdl/cfr_parser.sv */
// Frame parsing state and the per-item update of the command frame receiver.
module cfr_parser #(
   parameter int NUM_COMMANDS = cfr_pkg::NumCommandsDflt
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  cfr_pkg::item_type                     item,
   input  logic [cfr_pkg::TickWidth-1:0]         timeout,
   input  cfr_pkg::len_table_type                frame_len,
   output logic                                  res_valid,
   output cfr_pkg::result_type                   result
);
   import cfr_pkg::*;

   phase_type               phase_ff,  phase_in;
   logic [CmdWidth-1:0]     cmd_ff,    cmd_in;
   logic [ByteWidth-1:0]    len_hi_ff, len_hi_in;
   logic [LenWidth-1:0]     flen_ff,   flen_in;
   logic [LenWidth-1:0]     count_ff,  count_in;
   logic [ByteWidth-1:0]    sum_ff,    sum_in;
   logic [PayloadWidth-1:0] payload_ff, payload_in;
   logic [TickWidth-1:0]    ticks_ff,  ticks_in;

   logic [TickWidth-1:0]    ticks_inc;
   logic                    is_cmd;
   logic [LenWidth-1:0]     req_len;
   logic [2*ByteWidth:0]    total;
   logic                    len_ok;
   logic                    last;
   logic [LenWidth-1:0]     pcount_raw;
   logic [CountWidth-1:0]   pcount_sat;

   assign ticks_inc  = (ticks_ff != '1) ? ticks_ff + 1'b1 : ticks_ff;
   assign is_cmd     = (item.rx_byte != '0) && (item.rx_byte <= ByteWidth'(NUM_COMMANDS));
   assign total      = {1'b0, len_hi_ff, item.rx_byte} + (2*ByteWidth+1)'(HeaderBytes);
   assign len_ok     = (req_len >= LenWidth'(MinFrameLen)) &&
                       (total == (2*ByteWidth+1)'(req_len));
   assign last       = ({1'b0, count_ff} + 5'd1) >= {1'b0, flen_ff};
   assign pcount_raw = count_ff - LenWidth'(HeaderBytes);
   assign pcount_sat = (pcount_raw > LenWidth'(PayloadBytes)) ? CountWidth'(PayloadBytes)
                                                               : pcount_raw[CountWidth-1:0];

   always_comb begin
      req_len = '0;
      for (int i = 0; i < NumLenRegs; i++) begin
         if (cmd_ff == CmdWidth'(i + 1)) begin
            req_len = frame_len[i];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (item.mode) begin
         if (phase_ff != PhIdle && ticks_inc >= timeout) begin
            phase_in = PhIdle;
         end
      end else begin
         unique case (phase_ff)
            PhIdle: begin
               if (is_cmd) begin
                  phase_in = PhLenHi;
               end
            end
            PhLenHi: begin
               phase_in = PhLenLo;
            end
            PhLenLo: begin
               phase_in = len_ok ? PhBody : PhIdle;
            end
            PhBody: begin
               if (last) begin
                  phase_in = PhIdle;
               end
            end
            default: begin
               phase_in = PhIdle;
            end
         endcase
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      len_hi_in  = len_hi_ff;
      flen_in    = flen_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      payload_in = payload_ff;
      ticks_in   = ticks_ff;
      res_valid  = 1'b0;
      result.command       = cmd_ff;
      result.status        = (item.rx_byte != ~sum_ff);
      result.payload_count = pcount_sat;
      result.payload       = payload_ff;
      if (item.mode) begin
         if (phase_ff != PhIdle) begin
            ticks_in = ticks_inc;
         end
      end else begin
         ticks_in = '0;
         unique case (phase_ff)
            PhIdle: begin
               if (is_cmd) begin
                  cmd_in     = item.rx_byte[CmdWidth-1:0];
                  sum_in     = item.rx_byte;
                  count_in   = LenWidth'(1);
                  len_hi_in  = '0;
                  flen_in    = '0;
                  payload_in = '0;
               end
            end
            PhLenHi: begin
               len_hi_in = item.rx_byte;
               sum_in    = sum_ff + item.rx_byte;
               count_in  = LenWidth'(2);
            end
            PhLenLo: begin
               if (len_ok) begin
                  flen_in  = req_len;
                  sum_in   = sum_ff + item.rx_byte;
                  count_in = LenWidth'(HeaderBytes);
               end
            end
            PhBody: begin
               if (last) begin
                  res_valid = 1'b1;
               end else begin
                  for (int i = 0; i < PayloadBytes; i++) begin
                     if (pcount_raw == LenWidth'(i)) begin
                        payload_in[(PayloadBytes-1-i)*ByteWidth +: ByteWidth] = item.rx_byte;
                     end
                  end
                  sum_in   = sum_ff + item.rx_byte;
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhIdle;
         cmd_ff     <= '0;
         len_hi_ff  <= '0;
         flen_ff    <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
         payload_ff <= '0;
         ticks_ff   <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         cmd_ff     <= cmd_in;
         len_hi_ff  <= len_hi_in;
         flen_ff    <= flen_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         payload_ff <= payload_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule

/* hdl/command_frame_receiver.sv */
// Top level of the command frame receiver: input register, parser and result register.
// An item is registered at acceptance and parsed once the result register is free;
// the result of a frame's last byte is then registered in the result register.
// Throughput is one item per cycle, limited only by the result register draining.
// Synchronous reset empties both registers, returns the parser to idle and restores
// the configuration registers to their default values.
module command_frame_receiver #(
   parameter int NUM_COMMANDS = cfr_pkg::NumCommandsDflt
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cfr_req_if.sink                              req_ch,
   cfr_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [cfr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [cfr_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import cfr_pkg::*;

   logic                 in_valid_ff;
   item_type             item_ff;
   logic                 rsp_valid_ff;
   result_type           result_ff;
   logic [TickWidth-1:0] timeout_ff;
   len_table_type        frame_len_ff;

   logic                 out_free;
   logic                 fire;
   logic                 res_valid;
   result_type           result;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.mode    <= req_ch.mode;
         item_ff.rx_byte <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TimeoutReset;
         frame_len_ff <= LenTableReset;
      end else if (csr_we) begin
         if (csr_index == CsrTimeout) begin
            timeout_ff <= csr_wdata[TickWidth-1:0];
         end
         for (int i = 0; i < NumLenRegs; i++) begin
            if (csr_index == CsrFrameLenBase + CsrIndexWidth'(i)) begin
               frame_len_ff[i] <= csr_wdata[LenWidth-1:0];
            end
         end
      end
   end

   cfr_parser #(
      .NUM_COMMANDS (NUM_COMMANDS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .timeout   (timeout_ff),
      .frame_len (frame_len_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.command       = result_ff.command;
   assign rsp_ch.status        = result_ff.status;
   assign rsp_ch.payload_count = result_ff.payload_count;
   assign rsp_ch.payload       = result_ff.payload;

endmodule

/* hdl/cfr_checker.sv */
// Port-level checker for the command frame receiver, bound to the top level.
`include "assert_macros.svh"

module cfr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [cfr_pkg::CmdWidth-1:0]         rsp_command,
   input logic [cfr_pkg::CountWidth-1:0]       rsp_payload_count,
   input logic [cfr_pkg::PayloadWidth-1:0]     rsp_payload
);
   import cfr_pkg::*;

   `CFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CFR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload) && $stable(rsp_command))
   `CFR_ASSERT_NOW(a_rsp_fields, clock, reset, rsp_valid, (rsp_command != '0) && (rsp_payload_count <= CountWidth'(PayloadBytes)))
   `CFR_ASSERT_NOW(a_empty_payload, clock, reset, rsp_valid && (rsp_payload_count == '0), rsp_payload == '0)
   `CFR_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_command       (rsp_ch.command),
   .rsp_payload_count (rsp_ch.payload_count),
   .rsp_payload       (rsp_ch.payload)
);

/* dv/tb_command_frame_receiver.sv */
// Self-checking testbench for the command frame receiver, with its own frame predictor.
module tb_command_frame_receiver;
   import cfr_pkg::*;

   localparam int SettleCycles  = 8;
   localparam int DrainLimit    = 5000;
   localparam int RandomItems   = 1350;
   localparam int ItemsPerPhase = 150;

   localparam logic ModeByte = 1'b0;
   localparam logic ModeTick = 1'b1;

   localparam logic [TickWidth-1:0] LongTimeout = 16'd40;

   localparam logic [ByteWidth-1:0] Cmd1 = 8'd1;
   localparam logic [ByteWidth-1:0] Cmd2 = 8'd2;
   localparam logic [ByteWidth-1:0] Cmd3 = 8'd3;
   localparam logic [ByteWidth-1:0] Cmd4 = 8'd4;

   localparam logic [CsrIndexWidth-1:0] CsrLen1        = CsrFrameLenBase;
   localparam logic [CsrIndexWidth-1:0] CsrLen2        = CsrFrameLenBase + 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrLen3        = CsrFrameLenBase + 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrLen4        = CsrFrameLenBase + 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrFirstUnused = CsrFrameLenBase + 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrLastIndex   = '1;

   typedef enum int {StallNone, StallRandom, StallPeriodic, StallHeavy} stall_style_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   cfr_req_if req_ch();
   cfr_rsp_if rsp_ch();

   command_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [TickWidth-1:0]    cfg_timeout;
   logic [LenWidth-1:0]     cfg_len [NumLenRegs];
   phase_type               fr_phase;
   logic [CmdWidth-1:0]     fr_cmd;
   logic [ByteWidth-1:0]    fr_len_hi;
   logic [LenWidth-1:0]     fr_total;
   logic [LenWidth-1:0]     fr_count;
   logic [ByteWidth-1:0]    fr_sum;
   logic [PayloadWidth-1:0] fr_payload;
   logic [TickWidth-1:0]    fr_idle;

   result_type expected_frames [$];
   int         error_count;
   int         items_sent;
   bit         bursty;
   int         burst_left;
   int         hold_len;

   initial begin : clock_gen
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #6000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic reset_frame_model();
      int k;
      cfg_timeout = TimeoutReset;
      for (k = 0; k < NumLenRegs; k++) begin
         cfg_len[k] = LenTableReset[k];
      end
      fr_phase   = PhIdle;
      fr_cmd     = '0;
      fr_len_hi  = '0;
      fr_total   = '0;
      fr_count   = '0;
      fr_sum     = '0;
      fr_payload = '0;
      fr_idle    = '0;
   endtask

   // Advances the frame state by one accepted item and queues a result when a frame closes.
   task automatic track_frame_item(input logic mode, input logic [ByteWidth-1:0] b);
      result_type  done;
      int unsigned total;
      int          pcount;
      if (mode == ModeTick) begin
         if (fr_phase != PhIdle) begin
            if (fr_idle != '1) fr_idle = fr_idle + 1'b1;
            if (fr_idle >= cfg_timeout) fr_phase = PhIdle;
         end
      end else begin
         fr_idle = '0;
         case (fr_phase)
            PhIdle: begin
               if (b != 0 && b <= NumCommandsDflt) begin
                  fr_cmd     = b[CmdWidth-1:0];
                  fr_sum     = b;
                  fr_count   = 4'd1;
                  fr_len_hi  = '0;
                  fr_total   = '0;
                  fr_payload = '0;
                  fr_phase   = PhLenHi;
               end
            end
            PhLenHi: begin
               fr_len_hi = b;
               fr_sum    = fr_sum + b;
               fr_count  = 4'd2;
               fr_phase  = PhLenLo;
            end
            PhLenLo: begin
               total = {fr_len_hi, b} + HeaderBytes;
               if (cfg_len[fr_cmd - 1] >= MinFrameLen && total == cfg_len[fr_cmd - 1]) begin
                  fr_total = cfg_len[fr_cmd - 1];
                  fr_sum   = fr_sum + b;
                  fr_count = 4'd3;
                  fr_phase = PhBody;
               end else begin
                  fr_phase = PhIdle;
               end
            end
            default: begin
               if (int'(fr_count) + 1 >= int'(fr_total)) begin
                  pcount = (fr_count >= HeaderBytes) ? int'(fr_count) - HeaderBytes : 0;
                  if (pcount > PayloadBytes) pcount = PayloadBytes;
                  done.command       = fr_cmd;
                  done.status        = (b != ~fr_sum);
                  done.payload_count = pcount[CountWidth-1:0];
                  done.payload       = fr_payload;
                  expected_frames.push_back(done);
                  fr_phase = PhIdle;
               end else begin
                  pcount = int'(fr_count) - HeaderBytes;
                  if (pcount < PayloadBytes) begin
                     fr_payload[(PayloadBytes - 1 - pcount) * ByteWidth +: ByteWidth] = b;
                  end
                  fr_sum   = fr_sum + b;
                  fr_count = fr_count + 1'b1;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("result with none expected, command %0d",
                                      rsp_ch.command));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_ch.command !== want.command)
               report_mismatch($sformatf("command got %0d want %0d",
                                         rsp_ch.command, want.command));
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_ch.status, want.status));
            if (rsp_ch.payload_count !== want.payload_count)
               report_mismatch($sformatf("payload_count got %0d want %0d",
                                         rsp_ch.payload_count, want.payload_count));
            if (rsp_ch.payload !== want.payload)
               report_mismatch($sformatf("payload got %h want %h",
                                         rsp_ch.payload, want.payload));
         end
      end
   end

   // The result side stalls on its own pattern; a requested hold-off is counted here.
   initial begin : result_sink
      int              hold_left;
      int              style_left;
      int              cycle_count;
      stall_style_type style;
      hold_left     = 0;
      style_left    = 0;
      cycle_count   = 0;
      style         = StallNone;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
         end
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 200);
         end
         style_left--;
         if (hold_left != 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            case (style)
               StallNone:     rsp_ch.ready = 1'b1;
               StallRandom:   rsp_ch.ready = 1'($urandom_range(0, 1));
               StallPeriodic: rsp_ch.ready = (cycle_count % 5) != 0;
               default:       rsp_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_item(input logic mode, input logic [ByteWidth-1:0] data);
      int gap;
      gap = 0;
      if (bursty) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         burst_left--;
      end
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.mode    = mode;
      req_ch.rx_byte = data;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      track_frame_item(mode, data);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(ModeTick, 8'($urandom));
   endtask

   // Sends command, length, body and checksum; ticks may fall before every byte after the first.
   task automatic send_frame(input logic [ByteWidth-1:0] cmd, input logic [15:0] len_field,
                             input int body_len, input bit bad_sum, input int tick_max,
                             input bit extreme_fill);
      logic [ByteWidth-1:0] sum;
      logic [ByteWidth-1:0] data;
      int                   i;
      sum = '0;
      for (i = 0; i < body_len + 4; i++) begin
         if (i == 0) data = cmd;
         else if (i == 1) data = len_field[15:8];
         else if (i == 2) data = len_field[7:0];
         else if (i < body_len + 3) data = extreme_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
         else data = ~sum ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00);
         sum = sum + data;
         if (i != 0 && tick_max != 0) send_ticks($urandom_range(0, tick_max));
         send_item(ModeByte, data);
      end
   endtask

   task automatic wait_frames_done();
      int waited;
      waited = 0;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_frames.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (expected_frames.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
         expected_frames.delete();
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (index == CsrTimeout) cfg_timeout = data;
      else if (index >= CsrLen1 && index <= CsrLen4) cfg_len[index - CsrLen1] = data[LenWidth-1:0];
   endtask

   task automatic randomize_config();
      int                  k;
      logic [LenWidth-1:0] len;
      case ($urandom_range(0, 4))
         0:       write_reg(CsrTimeout, 16'd0);
         1:       write_reg(CsrTimeout, 16'($urandom_range(1, 3)));
         2:       write_reg(CsrTimeout, 16'($urandom_range(4, 16)));
         3:       write_reg(CsrTimeout, 16'hFFFF);
         default: write_reg(CsrTimeout, 16'($urandom));
      endcase
      for (k = 0; k < NumLenRegs; k++) begin
         len = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(MinFrameLen, 10));
         write_reg(CsrLen1 + 3'(k), {12'($urandom), len});
      end
      if ($urandom_range(0, 3) == 0)
         write_reg(3'($urandom_range(CsrFirstUnused, CsrLastIndex)), 16'($urandom));
   endtask

   task automatic test_reset_defaults();
      send_item(ModeTick, 8'hA5);
      send_item(ModeByte, 8'h00);
      send_item(ModeByte, 8'h05);
      send_item(ModeByte, 8'hFF);
      send_frame(Cmd1, 16'd1, 0, 1'b0, 0, 1'b0);
      send_frame(Cmd2, 16'd7, 6, 1'b0, 0, 1'b1);
      send_frame(Cmd3, 16'd1, 0, 1'b1, 0, 1'b0);
      send_frame(Cmd4, 16'd1, 0, 1'b0, 1, 1'b0);
      wait_frames_done();
   endtask

   task automatic test_result_backpressure();
      write_reg(CsrLen1, 16'd4);
      hold_len = 150;
      repeat (12) send_frame(Cmd1, 16'd1, 0, $urandom_range(0, 1), 0, 1'b0);
      wait_frames_done();
   endtask

   task automatic test_config_extremes();
      write_reg(CsrTimeout, 16'd0);
      write_reg(CsrLen1, 16'hFFFF);
      write_reg(CsrLen2, 16'd3);
      write_reg(CsrLen3, 16'd0);
      write_reg(CsrLen4, 16'hFFF4);
      write_reg(CsrFirstUnused, 16'd0);
      write_reg(CsrFirstUnused + 3'd1, 16'd0);
      write_reg(CsrLastIndex, 16'hFFFF);
      // More payload than the result can carry.
      send_frame(Cmd1, 16'd12, 11, 1'b0, 0, 1'b0);
      // Lengths below the smallest possible frame.
      send_frame(Cmd2, 16'd0, 0, 1'b0, 0, 1'b0);
      send_frame(Cmd3, 16'hFFFD, 0, 1'b0, 0, 1'b0);
      // A zero timeout drops the frame on its first tick.
      send_item(ModeByte, Cmd4);
      send_item(ModeTick, 8'h00);
      send_frame(Cmd4, 16'h0101, 0, 1'b0, 0, 1'b0);
      send_frame(Cmd4, 16'd1, 0, 1'b0, 0, 1'b0);
      wait_frames_done();
      write_reg(CsrTimeout, 16'd1);
      write_reg(CsrLen2, 16'd10);
      send_frame(Cmd2, 16'd7, 6, 1'b1, 0, 1'b1);
      send_frame(Cmd4, 16'd1, 0, 1'b0, 1, 1'b0);
      wait_frames_done();
   endtask

   task automatic test_timeout_limit();
      logic [ByteWidth-1:0] sum;
      write_reg(CsrTimeout, LongTimeout);
      write_reg(CsrLen1, 16'd5);
      bursty = 1'b0;
      sum = Cmd1 + 8'd2 + 8'h3C;
      send_item(ModeByte, Cmd1);
      send_item(ModeByte, 8'h00);
      send_item(ModeByte, 8'h02);
      send_item(ModeByte, 8'h3C);
      send_ticks(int'(LongTimeout) - 1);
      send_item(ModeByte, ~sum);
      send_item(ModeByte, Cmd1);
      send_item(ModeByte, 8'h00);
      send_item(ModeByte, 8'h02);
      send_ticks(int'(LongTimeout));
      send_item(ModeByte, 8'h3C);
      send_frame(Cmd1, 16'd2, 1, 1'b0, 0, 1'b0);
      bursty = 1'b1;
      wait_frames_done();
   endtask

   task automatic test_random_traffic();
      int                  base;
      int                  phase_base;
      int                  pick;
      int                  cmd_idx;
      int                  body_len;
      logic [LenWidth-1:0] need;
      logic [15:0]         len_field;
      base = items_sent;
      while (items_sent - base < RandomItems) begin
         wait_frames_done();
         randomize_config();
         phase_base = items_sent;
         while (items_sent - phase_base < ItemsPerPhase) begin
            pick      = $urandom_range(0, 99);
            cmd_idx   = $urandom_range(0, NumLenRegs - 1);
            need      = cfg_len[cmd_idx];
            len_field = 16'(need) - 16'(HeaderBytes);
            body_len  = (need >= MinFrameLen) ? int'(need) - MinFrameLen : 0;
            if (pick < 70) begin
               send_frame(Cmd1 + 8'(cmd_idx), len_field, body_len, $urandom_range(0, 7) == 0,
                          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                          $urandom_range(0, 15) == 0);
            end else if (pick < 80) begin
               send_frame(Cmd1 + 8'(cmd_idx), len_field + 16'($urandom_range(1, 65535)),
                          body_len, 1'b0, 0, 1'b0);
            end else if (pick < 88) begin
               send_item(ModeByte, Cmd1 + 8'(cmd_idx));
               if ($urandom_range(0, 1)) begin
                  send_item(ModeByte, len_field[15:8]);
                  send_item(ModeByte, len_field[7:0]);
               end
               send_ticks($urandom_range(0, 12));
            end else if (pick < 95) begin
               repeat ($urandom_range(1, 4)) send_item(ModeByte, 8'($urandom));
            end else begin
               send_ticks($urandom_range(1, 8));
            end
         end
      end
      wait_frames_done();
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.mode    = ModeByte;
      req_ch.rx_byte = '0;
      error_count    = 0;
      items_sent     = 0;
      bursty         = 1'b1;
      burst_left     = 0;
      hold_len       = 0;
      reset_frame_model();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_result_backpressure();
      test_config_extremes();
      test_timeout_limit();
      test_random_traffic();

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
